// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the encoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/brle_pkg.sv =====
// Shared constants and types of the byte run-length encoder.
`timescale 1ns / 1ps
package brle_pkg;

   localparam int BYTE_W      = 8;
   localparam int MAX_LITERAL = 128;
   localparam int MIN_REPEAT  = 3;
   localparam int MAX_REPEAT  = 130;
   localparam int COUNT_W     = 8;
   localparam int LIT_ADDR_W  = $clog2(MAX_LITERAL);
   localparam int TAIL_W      = 2;
   localparam int BITS_W      = 4;
   localparam int OUT_BYTES   = 8;
   localparam int PACK_IDX_W  = $clog2(OUT_BYTES);
   localparam int OUT_DATA_W  = OUT_BYTES * BYTE_W;
   localparam int OUT_CNT_W   = 4;
   localparam int RSP_DATA_W  = 72;
   localparam int REQ_USER_W  = 3;

   localparam int USR_OP      = 0;
   localparam int USR_NULL    = 1;
   localparam int USR_INV     = 2;

   localparam logic OP_ADD    = 1'b0;
   localparam logic OP_FLUSH  = 1'b1;

   typedef struct packed {
      logic                valid;
      logic                is_rep;
      logic [COUNT_W-1:0]  count;
      logic [BYTE_W-1:0]   value;
   } run_type;

   typedef enum logic [3:0] {
      SEQ_IDLE = 4'b0001,
      SEQ_HEAD = 4'b0010,
      SEQ_BODY = 4'b0100,
      SEQ_ACK  = 4'b1000
   } seq_state_type;

endpackage

// ===== rtl/core/brle_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module brle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/brle_emit.sv =====
// Run emitter: walks the run headers and literal bytes and packs them into result words.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module brle_emit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic                               ack,
   input  brle_pkg::run_type                  run_a,
   input  brle_pkg::run_type                  run_b,
   output logic                               busy,
   output logic                               rd_en,
   output logic [brle_pkg::LIT_ADDR_W-1:0]    rd_addr,
   input  logic [brle_pkg::BYTE_W-1:0]        rd_data,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [brle_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                               rsp_tlast
);
   import brle_pkg::*;

   seq_state_type              seq_ff, seq_in;
   run_type                    cur_ff, cur_in;
   run_type                    nxt_ff, nxt_in;
   logic [LIT_ADDR_W-1:0]      idx_ff, idx_in;

   logic                       s_valid, s_mem, s_last, s_empty, run_done;
   logic [BYTE_W-1:0]          s_imm;

   logic                       d_valid_ff, d_valid_in;
   logic                       d_mem_ff, d_last_ff, d_empty_ff;
   logic [BYTE_W-1:0]          d_imm_ff;

   logic [OUT_BYTES-1:0][BYTE_W-1:0] pack_ff, merged;
   logic [PACK_IDX_W-1:0]      pack_cnt_ff, pack_cnt_in;
   logic [OUT_DATA_W-1:0]      out_data_ff;
   logic [OUT_CNT_W-1:0]       out_cnt_ff;
   logic                       out_last_ff;
   logic                       rsp_valid_ff, rsp_valid_in;

   logic [BYTE_W-1:0]          cur_byte;
   logic                       need_out, out_free, consume, advance, load_out;

   always_comb begin
      seq_in   = seq_ff;
      cur_in   = cur_ff;
      nxt_in   = nxt_ff;
      idx_in   = idx_ff;
      s_valid  = 1'b0;
      s_mem    = 1'b0;
      s_imm    = '0;
      s_last   = 1'b0;
      s_empty  = 1'b0;
      run_done = 1'b0;
      unique case (seq_ff)
         SEQ_IDLE: begin
            if (start) begin
               if (ack) begin
                  seq_in = SEQ_ACK;
               end else if (run_a.valid) begin
                  cur_in = run_a;
                  nxt_in = run_b;
                  seq_in = SEQ_HEAD;
               end else begin
                  cur_in = run_b;
                  nxt_in = '0;
                  seq_in = SEQ_HEAD;
               end
            end
         end
         SEQ_HEAD: begin
            s_valid = 1'b1;
            s_imm   = cur_ff.is_rep ? cur_ff.count - COUNT_W'(MIN_REPEAT)
                                    : COUNT_W'(0) - cur_ff.count;
            if (advance) begin
               seq_in = SEQ_BODY;
               idx_in = '0;
            end
         end
         SEQ_BODY: begin
            s_valid = 1'b1;
            if (cur_ff.is_rep) begin
               s_imm    = cur_ff.value;
               run_done = 1'b1;
            end else begin
               s_mem    = 1'b1;
               run_done = (COUNT_W'(idx_ff) == cur_ff.count - COUNT_W'(1));
            end
            s_last = run_done && !nxt_ff.valid;
            if (advance) begin
               idx_in = idx_ff + LIT_ADDR_W'(1);
               if (run_done) begin
                  if (nxt_ff.valid) begin
                     cur_in = nxt_ff;
                     nxt_in = '0;
                     seq_in = SEQ_HEAD;
                  end else begin
                     seq_in = SEQ_IDLE;
                  end
               end
            end
         end
         SEQ_ACK: begin
            s_valid = 1'b1;
            s_empty = 1'b1;
            s_last  = 1'b1;
            if (advance) begin
               seq_in = SEQ_IDLE;
            end
         end
         default: begin
            seq_in = SEQ_IDLE;
         end
      endcase
   end

   assign busy    = (seq_ff != SEQ_IDLE);
   assign rd_en   = advance && (seq_ff == SEQ_BODY) && !cur_ff.is_rep;
   assign rd_addr = idx_ff;

   assign cur_byte = d_mem_ff ? rd_data : d_imm_ff;
   assign need_out = d_valid_ff && (d_empty_ff || d_last_ff ||
                                    pack_cnt_ff == PACK_IDX_W'(OUT_BYTES - 1));
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign consume  = d_valid_ff && (!need_out || out_free);
   assign advance  = !d_valid_ff || consume;
   assign load_out = consume && need_out;

   always_comb begin
      for (int k = 0; k < OUT_BYTES; k++) begin
         if (PACK_IDX_W'(k) < pack_cnt_ff) begin
            merged[k] = pack_ff[k];
         end else if (PACK_IDX_W'(k) == pack_cnt_ff) begin
            merged[k] = cur_byte;
         end else begin
            merged[k] = '0;
         end
      end
   end

   assign d_valid_in   = advance ? s_valid : d_valid_ff;
   assign pack_cnt_in  = !consume ? pack_cnt_ff :
                         need_out ? '0 : pack_cnt_ff + PACK_IDX_W'(1);
   assign rsp_valid_in = load_out ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= SEQ_IDLE;
         nxt_ff       <= '0;
         d_valid_ff   <= 1'b0;
         pack_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seq_ff       <= seq_in;
         nxt_ff       <= nxt_in;
         d_valid_ff   <= d_valid_in;
         pack_cnt_ff  <= pack_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      idx_ff <= idx_in;
      if (advance) begin
         d_mem_ff   <= s_mem;
         d_imm_ff   <= s_imm;
         d_last_ff  <= s_last;
         d_empty_ff <= s_empty;
      end
      if (consume && !need_out) begin
         pack_ff <= merged;
      end
      if (load_out) begin
         out_data_ff <= d_empty_ff ? '0 : merged;
         out_cnt_ff  <= d_empty_ff ? '0 : OUT_CNT_W'(pack_cnt_ff) + OUT_CNT_W'(1);
         out_last_ff <= d_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - OUT_DATA_W - OUT_CNT_W)'(0), out_cnt_ff, out_data_ff};
   assign rsp_tlast  = out_last_ff;

   `ASSERT_IMPLY(a_empty_is_last, clock, reset, rsp_valid_ff && out_cnt_ff == '0, out_last_ff, "empty result word without last")
   `ASSERT_NEXT(a_stalled_byte_kept, clock, reset, d_valid_ff && !consume, d_valid_ff && $stable(d_last_ff) && $stable(d_imm_ff), "stalled byte lost")
   `ASSERT_IMPLY(a_read_in_run, clock, reset, rd_en, COUNT_W'(idx_ff) < cur_ff.count, "literal read beyond run")

endmodule

// ===== rtl/core/byte_rle_encoder_top.sv =====
// Top level of the byte run-length encoder: bit packer, run former and literal memory.
// Throughput: one encoded byte per cycle while the result output does not stall. An item that
// emits bytes, or an empty flush, holds off the next item until the emitter has stepped through
// all of its bytes; any other item does not hold off the next.
// Reset clears the run state, the bit packer and the mode; the literal memory is not cleared.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module byte_rle_encoder_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [brle_pkg::BYTE_W-1:0]        req_tdata,   // value
   input  logic [brle_pkg::REQ_USER_W-1:0]    req_tuser,   // operation, is_null, invert
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [brle_pkg::RSP_DATA_W-1:0]    rsp_tdata,   // out_bytes, byte_count, zero pad
   output logic                               rsp_tlast,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic                               csr_data
);
   import brle_pkg::*;

   logic                    bool_mode_ff;
   logic [COUNT_W-1:0]      lit_count_ff, lit_count_in;
   logic                    rep_active_ff, rep_active_in;
   logic [TAIL_W-1:0]       tail_run_ff, tail_run_in, tail_nx;
   logic [BYTE_W-1:0]       run_byte_ff, run_byte_in;
   logic [BITS_W-1:0]       bits_left_ff, bits_left_in, bits_dec;
   logic [BYTE_W-1:0]       partial_ff, partial_in, partial_nx;

   logic                    accept, op, is_null, inv, busy;
   logic                    feed_en;
   logic [BYTE_W-1:0]       feed_val;
   logic                    wr_en;
   logic [LIT_ADDR_W-1:0]   wr_addr;
   logic [BYTE_W-1:0]       rd_data;
   logic                    rd_en;
   logic [LIT_ADDR_W-1:0]   rd_addr;
   run_type                 run_a, run_b;
   logic                    ack, start;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = !busy;
   assign csr_ready  = 1'b1;
   assign op         = req_tuser[USR_OP];
   assign is_null    = req_tuser[USR_NULL];
   assign inv        = req_tuser[USR_INV];

   assign bits_dec   = bits_left_ff - BITS_W'(1);
   assign partial_nx = partial_ff |
                       (BYTE_W'(req_tdata[0] ^ inv) << bits_dec[PACK_IDX_W-1:0]);

   always_comb begin
      feed_en      = 1'b0;
      feed_val     = req_tdata;
      bits_left_in = bits_left_ff;
      partial_in   = partial_ff;
      if (accept) begin
         if (op == OP_ADD) begin
            if (!is_null) begin
               if (bool_mode_ff) begin
                  if (bits_dec == '0) begin
                     feed_en      = 1'b1;
                     feed_val     = partial_nx;
                     bits_left_in = BITS_W'(BYTE_W);
                     partial_in   = '0;
                  end else begin
                     bits_left_in = bits_dec;
                     partial_in   = partial_nx;
                  end
               end else begin
                  feed_en = 1'b1;
               end
            end
         end else if (bits_left_ff != BITS_W'(BYTE_W)) begin
            feed_en      = 1'b1;
            feed_val     = partial_ff;
            bits_left_in = BITS_W'(BYTE_W);
            partial_in   = '0;
         end
      end
   end

   always_comb begin
      lit_count_in  = lit_count_ff;
      rep_active_in = rep_active_ff;
      tail_run_in   = tail_run_ff;
      run_byte_in   = run_byte_ff;
      run_a         = '0;
      run_b         = '0;
      wr_en         = 1'b0;
      wr_addr       = lit_count_ff[LIT_ADDR_W-1:0];
      tail_nx       = (feed_val == run_byte_ff) ? tail_run_ff + TAIL_W'(1) : TAIL_W'(1);
      if (feed_en) begin
         priority if (lit_count_ff == '0) begin
            wr_en         = 1'b1;
            wr_addr       = '0;
            lit_count_in  = COUNT_W'(1);
            tail_run_in   = TAIL_W'(1);
            rep_active_in = 1'b0;
            run_byte_in   = feed_val;
         end else if (rep_active_ff) begin
            if (feed_val == run_byte_ff) begin
               if (lit_count_ff + COUNT_W'(1) >= COUNT_W'(MAX_REPEAT)) begin
                  run_a         = '{valid: 1'b1, is_rep: 1'b1,
                                    count: COUNT_W'(MAX_REPEAT), value: run_byte_ff};
                  lit_count_in  = '0;
                  rep_active_in = 1'b0;
                  tail_run_in   = '0;
               end else begin
                  lit_count_in = lit_count_ff + COUNT_W'(1);
               end
            end else begin
               run_a         = '{valid: 1'b1, is_rep: 1'b1,
                                 count: lit_count_ff, value: run_byte_ff};
               wr_en         = 1'b1;
               wr_addr       = '0;
               lit_count_in  = COUNT_W'(1);
               tail_run_in   = TAIL_W'(1);
               rep_active_in = 1'b0;
               run_byte_in   = feed_val;
            end
         end else begin
            if (tail_nx == TAIL_W'(MIN_REPEAT)) begin
               if (lit_count_ff >= COUNT_W'(MIN_REPEAT)) begin
                  run_a = '{valid: 1'b1, is_rep: 1'b0,
                            count: lit_count_ff - COUNT_W'(MIN_REPEAT - 1), value: run_byte_ff};
               end
               rep_active_in = 1'b1;
               tail_run_in   = TAIL_W'(MIN_REPEAT);
               lit_count_in  = COUNT_W'(MIN_REPEAT);
               run_byte_in   = feed_val;
            end else begin
               wr_en        = 1'b1;
               lit_count_in = lit_count_ff + COUNT_W'(1);
               tail_run_in  = tail_nx;
               run_byte_in  = feed_val;
               if (lit_count_ff + COUNT_W'(1) >= COUNT_W'(MAX_LITERAL)) begin
                  run_a         = '{valid: 1'b1, is_rep: 1'b0,
                                    count: COUNT_W'(MAX_LITERAL), value: run_byte_ff};
                  lit_count_in  = '0;
                  tail_run_in   = '0;
                  rep_active_in = 1'b0;
               end
            end
         end
      end
      if (accept && op == OP_FLUSH) begin
         run_b         = '{valid: lit_count_in != '0, is_rep: rep_active_in,
                           count: lit_count_in, value: run_byte_in};
         lit_count_in  = '0;
         rep_active_in = 1'b0;
         tail_run_in   = '0;
      end
   end

   assign ack   = accept && (op == OP_FLUSH) && !run_a.valid && !run_b.valid;
   assign start = accept && (run_a.valid || run_b.valid || ack);

   always_ff @(posedge clock) begin
      if (reset) begin
         bool_mode_ff  <= 1'b0;
         lit_count_ff  <= '0;
         rep_active_ff <= 1'b0;
         tail_run_ff   <= '0;
         run_byte_ff   <= '0;
         bits_left_ff  <= BITS_W'(BYTE_W);
         partial_ff    <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            bool_mode_ff <= csr_data;
         end
         lit_count_ff  <= lit_count_in;
         rep_active_ff <= rep_active_in;
         tail_run_ff   <= tail_run_in;
         run_byte_ff   <= run_byte_in;
         bits_left_ff  <= bits_left_in;
         partial_ff    <= partial_in;
      end
   end

   brle_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (MAX_LITERAL)
   ) u_lit_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (feed_val),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   brle_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .ack        (ack),
      .run_a      (run_a),
      .run_b      (run_b),
      .busy       (busy),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   `ASSERT_ALWAYS(a_literal_bound, clock, reset, rep_active_ff || (lit_count_ff < COUNT_W'(MAX_LITERAL) && tail_run_ff != TAIL_W'(MIN_REPEAT)), "literal run state out of range")
   `ASSERT_ALWAYS(a_bits_range, clock, reset, bits_left_ff != '0 && bits_left_ff <= BITS_W'(BYTE_W), "bit packer count out of range")

endmodule

// ===== sim/tb_byte_rle_encoder_top.sv =====
// Self-checking testbench of the byte run-length encoder, with its own run and bit-packing predictor.
`timescale 1ns / 1ps
module tb_byte_rle_encoder_top;
   import brle_pkg::*;

   localparam int QUIET_LIMIT = 1000;
   localparam int IDLE_WAIT   = 8;
   localparam int END_WAIT    = 24;

   typedef struct packed {
      logic [OUT_DATA_W-1:0] word_bytes;
      logic [OUT_CNT_W-1:0]  count;
      logic                  last;
   } enc_word_type;

   typedef enum int {RX_OPEN, RX_SPARSE, RX_PERIODIC, RX_COIN} rx_style_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [BYTE_W-1:0]     req_tdata;
   logic [REQ_USER_W-1:0] req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_valid;
   logic                  csr_ready;
   logic                  csr_data;

   // Predictor state.
   logic [BYTE_W-1:0] run_store [MAX_LITERAL];
   int unsigned       run_len;
   bit                repeat_on;
   int unsigned       tail_len;
   int unsigned       bits_left;
   logic [BYTE_W-1:0] part_byte;
   bit                bool_mode_q;
   logic [BYTE_W-1:0] enc_bytes [$];
   enc_word_type      expected_words [$];

   int unsigned       error_count;
   int unsigned       sent_items;
   int unsigned       burst_left;
   int unsigned       quiet_cycles = 0;
   logic [BYTE_W-1:0] last_byte;

   byte_rle_encoder_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void emit_pending();
      int unsigned i;
      if (run_len == 0) return;
      if (repeat_on) begin
         enc_bytes.push_back(8'(run_len - MIN_REPEAT));
         enc_bytes.push_back(run_store[0]);
      end else begin
         enc_bytes.push_back(8'(256 - run_len));
         for (i = 0; i < run_len; i++) enc_bytes.push_back(run_store[i]);
      end
      repeat_on = 1'b0;
      tail_len  = 0;
      run_len   = 0;
   endfunction

   function automatic void feed_byte(input logic [BYTE_W-1:0] v);
      if (run_len == 0) begin
         run_store[0] = v;
         run_len      = 1;
         tail_len     = 1;
      end else if (repeat_on) begin
         if (v == run_store[0]) begin
            run_len++;
            if (run_len >= MAX_REPEAT) emit_pending();
         end else begin
            emit_pending();
            run_store[0] = v;
            run_len      = 1;
            tail_len     = 1;
         end
      end else begin
         if (v == run_store[(run_len - 1) % MAX_LITERAL]) tail_len = (tail_len + 1) % 4;
         else tail_len = 1;
         if (tail_len == MIN_REPEAT) begin
            // The literals ahead of the three equal bytes leave as their own run.
            if (run_len + 1 > MIN_REPEAT) begin
               run_len = run_len - (MIN_REPEAT - 1);
               emit_pending();
               run_store[0] = v;
            end
            repeat_on = 1'b1;
            tail_len  = MIN_REPEAT;
            run_len   = MIN_REPEAT;
         end else begin
            run_store[run_len % MAX_LITERAL] = v;
            run_len++;
            if (run_len >= MAX_LITERAL) emit_pending();
         end
      end
   endfunction

   function automatic void push_partial();
      feed_byte(part_byte);
      bits_left = BYTE_W;
      part_byte = '0;
   endfunction

   function automatic void feed_bit(input bit b);
      if (bits_left == 0 || bits_left > BYTE_W) bits_left = BYTE_W;
      bits_left--;
      part_byte = part_byte | (8'(b) << bits_left);
      if (bits_left == 0) push_partial();
   endfunction

   function automatic void predict_words(input logic op, input logic [BYTE_W-1:0] v,
                                         input logic nul, input logic inv);
      enc_word_type w;
      int unsigned  pos;
      int unsigned  n;
      int unsigned  k;
      enc_bytes.delete();
      if (op == OP_ADD) begin
         if (nul) return;
         if (bool_mode_q) feed_bit(v[0] ^ inv);
         else feed_byte(v);
      end else begin
         if (bits_left != BYTE_W) push_partial();
         emit_pending();
         if (enc_bytes.size() == 0) begin
            w.word_bytes = '0;
            w.count      = '0;
            w.last       = 1'b1;
            expected_words.push_back(w);
            return;
         end
      end
      for (pos = 0; pos < enc_bytes.size(); pos += OUT_BYTES) begin
         n = enc_bytes.size() - pos;
         if (n > OUT_BYTES) n = OUT_BYTES;
         w.word_bytes = '0;
         for (k = 0; k < n; k++) w.word_bytes[BYTE_W*k +: BYTE_W] = enc_bytes[pos + k];
         w.count = OUT_CNT_W'(n);
         w.last  = (pos + n >= enc_bytes.size());
         expected_words.push_back(w);
      end
   endfunction

   function automatic logic [BYTE_W-1:0] pick_byte();
      case ($urandom_range(0, 3))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Called at a falling edge; returns at the falling edge after the transaction.
   task automatic send_item(input logic op, input logic [BYTE_W-1:0] v,
                            input logic nul, input logic inv);
      logic [REQ_USER_W-1:0] user;
      int unsigned           gap;
      user           = '0;
      user[USR_OP]   = op;
      user[USR_NULL] = nul;
      user[USR_INV]  = inv;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= v;
      req_tuser  <= user;
      do @(posedge clock); while (!req_tready);
      predict_words(op, v, nul, inv);
      sent_items++;
      @(negedge clock);
   endtask

   task automatic add_byte(input logic [BYTE_W-1:0] v);
      send_item(OP_ADD, v, 1'b0, 1'($urandom_range(0, 1)));
      last_byte = v;
   endtask

   task automatic add_fresh_byte();
      logic [BYTE_W-1:0] v;
      do v = 8'($urandom_range(0, 255)); while (v == last_byte);
      add_byte(v);
   endtask

   task automatic add_bit(input bit b);
      logic              inv;
      logic [BYTE_W-1:0] v;
      inv  = 1'($urandom_range(0, 1));
      v    = 8'($urandom_range(0, 255));
      v[0] = b ^ inv;
      send_item(OP_ADD, v, 1'b0, inv);
   endtask

   task automatic add_null();
      send_item(OP_ADD, 8'($urandom_range(0, 255)), 1'b1, 1'($urandom_range(0, 1)));
   endtask

   task automatic flush_run();
      send_item(OP_FLUSH, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (IDLE_WAIT) @(negedge clock);
   endtask

   task automatic csr_write(input logic mode);
      wait_idle();
      csr_valid <= 1'b1;
      csr_data  <= mode;
      do @(posedge clock); while (!csr_ready);
      bool_mode_q = mode;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic test_empty_flush();
      csr_write(1'b0);
      flush_run();
   endtask

   task automatic test_byte_literals();
      add_byte(8'h00);
      add_byte(8'hFF);
      add_null();
      add_byte(8'hFF);
      flush_run();
   endtask

   task automatic test_repeat_runs();
      add_byte(8'h01);
      repeat (4) add_byte(8'h07);
      add_byte(8'h09);
      flush_run();
   endtask

   task automatic test_bool_packing();
      logic [BYTE_W-1:0] pattern;
      int                i;
      pattern = 8'hA5;
      csr_write(1'b1);
      for (i = BYTE_W - 1; i >= 0; i--) add_bit(pattern[i]);
      flush_run();
   endtask

   // A partial byte survives byte-mode adds and is pushed by the flush.
   task automatic test_mode_switch();
      add_bit(1'b1);
      add_bit(1'b0);
      add_bit(1'b1);
      csr_write(1'b0);
      add_byte(8'h33);
      flush_run();
   endtask

   task automatic test_random_bytes(input int unsigned target);
      int unsigned       start;
      int unsigned       rep_at;
      int unsigned       lit_at;
      int unsigned       kind;
      bit                rep_done;
      bit                lit_done;
      logic [BYTE_W-1:0] v;
      csr_write(1'b0);
      start    = sent_items;
      rep_at   = start + $urandom_range(2, 6);
      lit_at   = rep_at + $urandom_range(132, 136);
      rep_done = 1'b0;
      lit_done = 1'b0;
      while (sent_items - start < target || !rep_done || !lit_done) begin
         if ($urandom_range(0, 11) == 0) add_null();
         kind = $urandom_range(0, 7);
         if (!rep_done && sent_items >= rep_at) begin
            v = pick_byte();
            repeat (MAX_REPEAT + $urandom_range(0, 4)) add_byte(v);
            rep_done = 1'b1;
         end else if (!lit_done && sent_items >= lit_at) begin
            repeat (MAX_LITERAL + $urandom_range(0, 3)) add_fresh_byte();
            lit_done = 1'b1;
         end else if (kind == 0) begin
            flush_run();
         end else if (kind < 4) begin
            v = pick_byte();
            repeat ($urandom_range(1, 6)) add_byte(v);
         end else begin
            repeat ($urandom_range(1, 8)) add_fresh_byte();
         end
      end
   endtask

   task automatic test_random_bits(input int unsigned target);
      int unsigned       start;
      int unsigned       kind;
      int                i;
      logic [BYTE_W-1:0] pattern;
      csr_write(1'b1);
      start = sent_items;
      while (sent_items - start < target) begin
         if ($urandom_range(0, 11) == 0) add_null();
         kind = $urandom_range(0, 7);
         if (kind == 0) begin
            flush_run();
         end else if (kind == 1) begin
            repeat ($urandom_range(1, 7)) add_bit(1'($urandom_range(0, 1)));
         end else begin
            pattern = pick_byte();
            repeat ($urandom_range(1, 4))
               for (i = BYTE_W - 1; i >= 0; i--) add_bit(pattern[i]);
         end
      end
   endtask

   task automatic log_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
      $display("%0t: %s mismatch, got %h, expected %h", $time, what, got, want);
      error_count++;
   endtask

   initial begin
      rx_style_type style;
      int unsigned  style_left;
      rsp_tready = 1'b0;
      style      = RX_OPEN;
      style_left = 0;
      forever begin
         @(negedge clock);
         if (style_left == 0) begin
            style      = rx_style_type'($urandom_range(0, 3));
            style_left = $urandom_range(16, 80);
         end
         style_left--;
         case (style)
            RX_OPEN:     rsp_tready <= 1'b1;
            RX_SPARSE:   rsp_tready <= ($urandom_range(0, 3) != 0);
            RX_PERIODIC: rsp_tready <= (style_left % 3 == 0);
            default:     rsp_tready <= 1'($urandom_range(0, 1));
         endcase
      end
   end

   always @(posedge clock) begin
      enc_word_type got;
      enc_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.word_bytes = rsp_tdata[OUT_DATA_W-1:0];
         got.count      = rsp_tdata[OUT_DATA_W +: OUT_CNT_W];
         got.last       = rsp_tlast;
         if (expected_words.size() == 0) begin
            log_mismatch("unexpected result", got.word_bytes, '0);
         end else begin
            want = expected_words.pop_front();
            if (got.word_bytes !== want.word_bytes)
               log_mismatch("out_bytes", got.word_bytes, want.word_bytes);
            if (got.count !== want.count)
               log_mismatch("byte_count", 64'(got.count), 64'(want.count));
            if (got.last !== want.last)
               log_mismatch("last", 64'(got.last), 64'(want.last));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      csr_valid   = 1'b0;
      csr_data    = 1'b0;
      run_len     = 0;
      repeat_on   = 1'b0;
      tail_len    = 0;
      bits_left   = BYTE_W;
      part_byte   = '0;
      bool_mode_q = 1'b0;
      last_byte   = '0;
      error_count = 0;
      sent_items  = 0;
      burst_left  = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_flush();
      test_byte_literals();
      test_repeat_runs();
      test_bool_packing();
      test_mode_switch();
      test_random_bytes(240);
      test_random_bits(12);
      flush_run();

      wait_idle();
      repeat (END_WAIT) @(posedge clock);
      if (error_count == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule
